>>> src/ume_pkg.sv
// Shared definitions for the universal machine execute unit:
// opcodes, result action codes, field positions and control/status structs.
// No dependencies.
package ume_pkg;

    localparam int WORD_W = 32;
    localparam int ACT_W  = 4;
    localparam int OP_W   = 4;
    localparam int IDX_W  = 3;
    localparam int CHAR_W = 8;

    localparam logic [WORD_W-1:0] ALL_ONES = 32'hffff_ffff;
    localparam int OP_SHIFT      = 28;
    localparam int IMM_REG_SHIFT = 25;
    localparam int IMM_W         = 25;
    localparam int A_SHIFT       = 6;
    localparam int B_SHIFT       = 3;

    // opcodes
    localparam logic [OP_W-1:0] OP_CMOV    = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD    = 4'd1;
    localparam logic [OP_W-1:0] OP_STORE   = 4'd2;
    localparam logic [OP_W-1:0] OP_ADD     = 4'd3;
    localparam logic [OP_W-1:0] OP_MUL     = 4'd4;
    localparam logic [OP_W-1:0] OP_DIV     = 4'd5;
    localparam logic [OP_W-1:0] OP_NAND    = 4'd6;
    localparam logic [OP_W-1:0] OP_HALT    = 4'd7;
    localparam logic [OP_W-1:0] OP_MAP     = 4'd8;
    localparam logic [OP_W-1:0] OP_UNMAP   = 4'd9;
    localparam logic [OP_W-1:0] OP_OUTPUT  = 4'd10;
    localparam logic [OP_W-1:0] OP_INPUT   = 4'd11;
    localparam logic [OP_W-1:0] OP_LOADPRG = 4'd12;
    localparam logic [OP_W-1:0] OP_LOADIMM = 4'd13;

    // result actions
    localparam logic [ACT_W-1:0] ACT_DONE     = 4'd0;
    localparam logic [ACT_W-1:0] ACT_READ     = 4'd1;
    localparam logic [ACT_W-1:0] ACT_WRITE    = 4'd2;
    localparam logic [ACT_W-1:0] ACT_MAP      = 4'd3;
    localparam logic [ACT_W-1:0] ACT_UNMAP    = 4'd4;
    localparam logic [ACT_W-1:0] ACT_OUT      = 4'd5;
    localparam logic [ACT_W-1:0] ACT_IN       = 4'd6;
    localparam logic [ACT_W-1:0] ACT_LOADPROG = 4'd7;
    localparam logic [ACT_W-1:0] ACT_HALT     = 4'd8;
    localparam logic [ACT_W-1:0] ACT_ERROR    = 4'd9;

    localparam logic KIND_INSTR = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    typedef struct packed {
        logic             capture;
        logic             rd_a;
        logic             mul_load;
        logic             div_start;
        logic             commit;
        logic             err;
        logic [IDX_W-1:0] reply_dest;
        logic             reply_is_input;
    } ume_cmd_t;

    typedef struct packed {
        logic             kind;
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] c;
        logic             vc_zero;
        logic             div_done;
        logic             out_free;
    } ume_status_t;

endpackage

>>> src/ume_regfile.sv
// Eight-entry register file: one write port, two registered read ports.
// Per-entry valid bits give the all-zero reset. Uses ume_pkg.
module ume_regfile (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        we,
    input  logic [ume_pkg::IDX_W-1:0]   waddr,
    input  logic [ume_pkg::WORD_W-1:0]  wdata,
    input  logic                        re0,
    input  logic [ume_pkg::IDX_W-1:0]   raddr0,
    input  logic                        re1,
    input  logic [ume_pkg::IDX_W-1:0]   raddr1,
    output logic [ume_pkg::WORD_W-1:0]  rdata0,
    output logic [ume_pkg::WORD_W-1:0]  rdata1
);
    import ume_pkg::*;

    localparam int DEPTH = 1 << IDX_W;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [WORD_W-1:0] rdata0_reg;
    logic [WORD_W-1:0] rdata1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    // an entry never written reads as zero
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re0)
        begin
            rdata0_reg <= valid_reg[raddr0] ? mem[raddr0] : '0;
        end
        if (re1)
        begin
            rdata1_reg <= valid_reg[raddr1] ? mem[raddr1] : '0;
        end
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

>>> src/ume_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Holds the quotient after done until the next start. Uses ume_pkg.
module ume_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ume_pkg::WORD_W-1:0]  dividend,
    input  logic [ume_pkg::WORD_W-1:0]  divisor,
    output logic                        done,
    output logic [ume_pkg::WORD_W-1:0]  quotient
);
    import ume_pkg::*;

    localparam int CNT_W = $clog2(WORD_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(WORD_W - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] quot_reg;
    logic [WORD_W-1:0] dvs_reg;

    logic [WORD_W:0]   shifted;
    logic [WORD_W:0]   trial;
    logic [WORD_W-1:0] rem_next;
    logic [WORD_W-1:0] quot_next;

    always_comb
    begin
        shifted = {rem_reg, quot_reg[WORD_W-1]};
        trial   = shifted - {1'b0, dvs_reg};
        if (!trial[WORD_W])
        begin
            rem_next  = trial[WORD_W-1:0];
            quot_next = {quot_reg[WORD_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = shifted[WORD_W-1:0];
            quot_next = {quot_reg[WORD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg + 1'b1;
            if (count_reg == LAST)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quot_reg <= dividend;
            dvs_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

>>> src/ume_datapath.sv
// Datapath: item capture, register file, multiplier, divider, result
// assembly and output register. Uses ume_pkg, ume_regfile, ume_divider.
module ume_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ume_pkg::ume_cmd_t           cmd,
    output ume_pkg::ume_status_t        status,
    input  logic                        kind,
    input  logic [ume_pkg::WORD_W-1:0]  instruction,
    input  logic [ume_pkg::WORD_W-1:0]  reply_value,
    input  logic                        input_at_end,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ume_pkg::ACT_W-1:0]   action,
    output logic [ume_pkg::WORD_W-1:0]  segment,
    output logic [ume_pkg::WORD_W-1:0]  offset,
    output logic [ume_pkg::WORD_W-1:0]  store_value,
    output logic [ume_pkg::CHAR_W-1:0]  out_char,
    output logic                        wrote_register,
    output logic [ume_pkg::IDX_W-1:0]   written_index,
    output logic [ume_pkg::WORD_W-1:0]  written_value
);
    import ume_pkg::*;

    logic              kind_reg;
    logic [WORD_W-1:0] instr_reg;
    logic [WORD_W-1:0] rv_reg;
    logic              end_reg;
    logic [WORD_W-1:0] hold_reg;
    logic [WORD_W-1:0] prod_reg;

    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  fa;
    logic [IDX_W-1:0]  fb;
    logic [IDX_W-1:0]  fc;

    logic [IDX_W-1:0]  raddr0;
    logic [WORD_W-1:0] rd0;
    logic [WORD_W-1:0] rd1;
    logic [WORD_W-1:0] mul_low;
    logic              div_done;
    logic [WORD_W-1:0] quotient;

    logic [ACT_W-1:0]  res_action;
    logic [WORD_W-1:0] res_segment;
    logic [WORD_W-1:0] res_offset;
    logic [WORD_W-1:0] res_store;
    logic [CHAR_W-1:0] res_char;
    logic              res_wr;
    logic [IDX_W-1:0]  res_idx;
    logic [WORD_W-1:0] res_val;

    logic              out_valid_reg;
    logic [ACT_W-1:0]  action_reg;
    logic [WORD_W-1:0] segment_reg;
    logic [WORD_W-1:0] offset_reg;
    logic [WORD_W-1:0] store_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              wrote_reg;
    logic [IDX_W-1:0]  index_reg;
    logic [WORD_W-1:0] value_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg  <= kind;
            instr_reg <= instruction;
            rv_reg    <= reply_value;
            end_reg   <= input_at_end;
        end
        if (cmd.rd_a)
        begin
            hold_reg <= rd0;
        end
        if (cmd.mul_load)
        begin
            prod_reg <= mul_low;
        end
    end

    assign op = instr_reg[OP_SHIFT +: OP_W];
    assign fa = instr_reg[A_SHIFT +: IDX_W];
    assign fb = instr_reg[B_SHIFT +: IDX_W];
    assign fc = instr_reg[IDX_W-1:0];

    // port 0 reads b at capture, then a for a store
    assign raddr0 = cmd.rd_a ? fa : instruction[B_SHIFT +: IDX_W];

    ume_regfile u_regfile (
        .clk    (clk),
        .rst_n  (rst_n),
        .we     (cmd.commit && res_wr),
        .waddr  (res_idx),
        .wdata  (res_val),
        .re0    (cmd.capture || cmd.rd_a),
        .raddr0 (raddr0),
        .re1    (cmd.capture),
        .raddr1 (instruction[IDX_W-1:0]),
        .rdata0 (rd0),
        .rdata1 (rd1)
    );

    assign mul_low = rd0 * rd1;

    ume_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (rd0),
        .divisor  (rd1),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        res_action  = ACT_DONE;
        res_segment = '0;
        res_offset  = '0;
        res_store   = '0;
        res_char    = '0;
        res_wr      = 1'b0;
        res_idx     = '0;
        res_val     = '0;
        priority if (cmd.err)
        begin
            res_action = ACT_ERROR;
        end
        else if (kind_reg == KIND_REPLY)
        begin
            res_wr  = 1'b1;
            res_idx = cmd.reply_dest;
            res_val = (cmd.reply_is_input && end_reg) ? ALL_ONES : rv_reg;
        end
        else
        begin
            unique case (op)
                OP_CMOV:
                begin
                    res_wr  = (rd1 != '0);
                    res_idx = res_wr ? fa : '0;
                    res_val = res_wr ? rd0 : '0;
                end
                OP_LOAD:
                begin
                    res_action  = ACT_READ;
                    res_segment = rd0;
                    res_offset  = rd1;
                end
                OP_STORE:
                begin
                    // rd0 holds a here, b was parked in hold_reg
                    res_action  = ACT_WRITE;
                    res_segment = rd0;
                    res_offset  = hold_reg;
                    res_store   = rd1;
                end
                OP_ADD:
                begin
                    res_wr  = 1'b1;
                    res_idx = fa;
                    res_val = rd0 + rd1;
                end
                OP_MUL:
                begin
                    res_wr  = 1'b1;
                    res_idx = fa;
                    res_val = prod_reg;
                end
                OP_DIV:
                begin
                    res_wr  = 1'b1;
                    res_idx = fa;
                    res_val = quotient;
                end
                OP_NAND:
                begin
                    res_wr  = 1'b1;
                    res_idx = fa;
                    res_val = ~(rd0 & rd1);
                end
                OP_HALT:    res_action = ACT_HALT;
                OP_MAP:
                begin
                    res_action = ACT_MAP;
                    res_offset = rd1;
                end
                OP_UNMAP:
                begin
                    res_action  = ACT_UNMAP;
                    res_segment = rd1;
                end
                OP_OUTPUT:
                begin
                    res_action = ACT_OUT;
                    res_char   = rd1[CHAR_W-1:0];
                end
                OP_INPUT:   res_action = ACT_IN;
                OP_LOADPRG:
                begin
                    res_action  = ACT_LOADPROG;
                    res_segment = rd0;
                    res_offset  = rd1;
                end
                OP_LOADIMM:
                begin
                    res_wr  = 1'b1;
                    res_idx = instr_reg[IMM_REG_SHIFT +: IDX_W];
                    res_val = {{(WORD_W-IMM_W){1'b0}}, instr_reg[IMM_W-1:0]};
                end
                default:    res_action = ACT_ERROR;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            action_reg  <= res_action;
            segment_reg <= res_segment;
            offset_reg  <= res_offset;
            store_reg   <= res_store;
            char_reg    <= res_char;
            wrote_reg   <= res_wr;
            index_reg   <= res_idx;
            value_reg   <= res_val;
        end
    end

    assign status.kind     = kind_reg;
    assign status.op       = op;
    assign status.a        = fa;
    assign status.b        = fb;
    assign status.c        = fc;
    assign status.vc_zero  = (rd1 == '0);
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_valid      = out_valid_reg;
    assign action         = action_reg;
    assign segment        = segment_reg;
    assign offset         = offset_reg;
    assign store_value    = store_reg;
    assign out_char       = char_reg;
    assign wrote_register = wrote_reg;
    assign written_index  = index_reg;
    assign written_value  = value_reg;

endmodule

>>> src/ume_ctrl.sv
// Controller: sequencing state machine plus halt and pending-reply state.
// Drives datapath commands from datapath status. Uses ume_pkg.
module ume_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  ume_pkg::ume_status_t  status,
    output ume_pkg::ume_cmd_t     cmd
);
    import ume_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_STORE  = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic             halted_reg;
    logic             awaiting_reg;
    logic [IDX_W-1:0] dest_reg;
    logic             is_input_reg;

    logic             err_cond;

    always_comb
    begin
        if (halted_reg)
        begin
            err_cond = 1'b1;
        end
        else if (status.kind == KIND_REPLY)
        begin
            err_cond = !awaiting_reg;
        end
        else
        begin
            err_cond = awaiting_reg || (status.op > OP_LOADIMM)
                       || (status.op == OP_DIV && status.vc_zero);
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        cmd                = '0;
        cmd.reply_dest     = dest_reg;
        cmd.reply_is_input = is_input_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.err = err_cond;
                priority if (!err_cond && status.kind == KIND_INSTR
                             && status.op == OP_STORE)
                begin
                    cmd.rd_a   = 1'b1;
                    state_next = S_STORE;
                end
                else if (!err_cond && status.kind == KIND_INSTR
                         && status.op == OP_MUL)
                begin
                    cmd.mul_load = 1'b1;
                    state_next   = S_MUL;
                end
                else if (!err_cond && status.kind == KIND_INSTR
                         && status.op == OP_DIV)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_STORE, S_MUL:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (status.div_done && status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            halted_reg   <= 1'b0;
            awaiting_reg <= 1'b0;
            dest_reg     <= '0;
            is_input_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.commit && !cmd.err)
            begin
                if (status.kind == KIND_REPLY)
                begin
                    awaiting_reg <= 1'b0;
                    is_input_reg <= 1'b0;
                end
                else
                begin
                    unique case (status.op)
                        OP_LOAD:
                        begin
                            awaiting_reg <= 1'b1;
                            dest_reg     <= status.a;
                            is_input_reg <= 1'b0;
                        end
                        OP_MAP:
                        begin
                            awaiting_reg <= 1'b1;
                            dest_reg     <= status.b;
                            is_input_reg <= 1'b0;
                        end
                        OP_INPUT:
                        begin
                            awaiting_reg <= 1'b1;
                            dest_reg     <= status.c;
                            is_input_reg <= 1'b1;
                        end
                        OP_HALT:    halted_reg <= 1'b1;
                        default:    halted_reg <= halted_reg;
                    endcase
                end
            end
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

>>> src/universal_machine_execute_unit.sv
// Universal machine execute unit, one item at a time. Store and multiply
// pass through S_STORE or S_MUL (second register-file read, registered
// product); divide waits in S_DIV for the divider (one quotient bit per cycle).
// The result is loaded into the output register at commit, and the
// next item is taken while that result waits. Async active-low reset clears
// the registers (via valid bits), halt and pending-reply state; no clear pass.
module universal_machine_execute_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [31:0] instruction,
    input  logic [31:0] reply_value,
    input  logic        input_at_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  action,
    output logic [31:0] segment,
    output logic [31:0] offset,
    output logic [31:0] store_value,
    output logic [7:0]  out_char,
    output logic        wrote_register,
    output logic [2:0]  written_index,
    output logic [31:0] written_value
);
    import ume_pkg::*;

    ume_cmd_t    cmd;
    ume_status_t status;

    ume_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    ume_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .kind           (kind),
        .instruction    (instruction),
        .reply_value    (reply_value),
        .input_at_end   (input_at_end),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .action         (action),
        .segment        (segment),
        .offset         (offset),
        .store_value    (store_value),
        .out_char       (out_char),
        .wrote_register (wrote_register),
        .written_index  (written_index),
        .written_value  (written_value)
    );

    // a result is never loaded over one that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid || !out_stall))
        else $error("result committed while output register full");

    // an item is never taken in the cycle another one finishes
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(in_valid && !in_stall))
        else $error("input transfer overlaps commit");

    // commit is never asserted right after a divider start
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !cmd.commit)
        else $error("commit right after divider start");

    // error results carry nothing but the action code
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && action == ACT_ERROR) |-> (segment == '0 && offset == '0
            && store_value == '0 && out_char == '0 && !wrote_register
            && written_index == '0 && written_value == '0))
        else $error("error result with nonzero fields");

endmodule
